### hw/rtl/gpl_pkg.sv
`timescale 1ns / 1ps

package gpl_pkg;

  localparam int POINT_W            = 32;
  localparam int POS_W              = 8;
  localparam int CHAN_W             = 8;
  localparam int NUM_CHAN           = 3;
  localparam int COUNT_W            = 3;
  localparam int CFG_IDX_W          = 3;
  localparam int NUM_W              = 2 * CHAN_W;
  localparam int DIV_BITS           = 2;
  localparam int DIV_STAGES         = CHAN_W / DIV_BITS;
  localparam int DEFAULT_MAX_POINTS = 7;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = CFG_IDX_W'(0);
  localparam int                   REG_POINT_BASE  = 1;

  localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(2);
  localparam logic [POINT_W-1:0] POINT1_RESET = {POINT_W{1'b1}};

  typedef logic [CHAN_W-1:0]               chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] colour_t;
  typedef logic [NUM_CHAN-1:0][NUM_W-1:0]  wide_t;

  function automatic logic [POS_W-1:0] pt_pos(input logic [POINT_W-1:0] p);
    return p[POINT_W-1 -: POS_W];
  endfunction

  function automatic colour_t pt_colour(input logic [POINT_W-1:0] p);
    colour_t col;
    for (int c = 0; c < NUM_CHAN; c++) begin
      col[c] = p[NUM_CHAN*CHAN_W-1-c*CHAN_W -: CHAN_W];
    end
    return col;
  endfunction

endpackage

### hw/rtl/gpl_if.sv
`timescale 1ns / 1ps

interface gpl_in_if import gpl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    intensity;

  modport source (output valid, output intensity, input ready);
  modport sink   (input valid, input intensity, output ready);
endinterface

interface gpl_out_if import gpl_pkg::*; ();
  logic                valid;
  logic                ready;
  chan_t               chan_zero;
  chan_t               chan_one;
  chan_t               chan_two;
  logic                empty_error;

  modport source (output valid, output chan_zero, output chan_one, output chan_two,
                  output empty_error, input ready);
  modport sink   (input valid, input chan_zero, input chan_one, input chan_two,
                  input empty_error, output ready);
endinterface

### hw/rtl/gradient_palette_lookup.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle unless the output stalls; an eight-stage
// pipeline with a valid bit per stage, where a stalled stage holds and an empty
// stage still takes new data. Reset clears every valid bit and returns the
// palette registers to their defaults.

module gradient_palette_lookup import gpl_pkg::*; #(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POINT_W-1:0]   cfg_data,
  gpl_in_if.sink               pix_in,
  gpl_out_if.source            pix_out
);

  localparam int SEL_W  = $clog2(MAX_POINTS);
  localparam int STAGES = 4 + DIV_STAGES;

  logic [COUNT_W-1:0] point_count;
  logic [POINT_W-1:0] points [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_RESET;
      for (int i = 0; i < MAX_POINTS; i++) begin
        points[i] <= (i == 1) ? POINT1_RESET : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_POINT_COUNT) begin
        point_count <= cfg_data[COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_POINT_BASE + i)) begin
          points[i] <= cfg_data;
        end
      end
    end
  end

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   rdy;

  always_comb begin
    rdy[STAGES] = pix_out.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign pix_in.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? pix_in.valid : vld[k-1];
        end
      end
    end
  end

  // Search for the first point in use whose position exceeds the intensity.
  logic [COUNT_W-1:0] n_eff;
  logic               empty;
  logic               found;
  logic [SEL_W-1:0]   first;
  logic [SEL_W-1:0]   sel;
  logic [SEL_W-1:0]   sel_prev;
  logic               direct0;

  assign n_eff = (point_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : point_count;
  assign empty = (n_eff == '0);

  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if ((COUNT_W'(i) < n_eff) && (pix_in.intensity < pt_pos(points[i]))) begin
        found = 1'b1;
        first = SEL_W'(i);
      end
    end
    sel      = found ? first : SEL_W'(n_eff - COUNT_W'(1));
    sel_prev = (sel == '0) ? '0 : sel - SEL_W'(1);
    direct0  = empty || !found || (sel == '0);
  end

  logic [POS_W-1:0]   s1_v;
  logic [POINT_W-1:0] s1_cur;
  logic [POINT_W-1:0] s1_prev;
  logic               s1_direct;
  logic               s1_empty;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_v      <= pix_in.intensity;
      s1_cur    <= empty ? '0 : points[sel];
      s1_prev   <= empty ? '0 : points[sel_prev];
      s1_direct <= direct0;
      s1_empty  <= empty;
    end
  end

  logic [POS_W-1:0] pos1;
  logic [POS_W-1:0] pprev1;

  assign pos1   = pt_pos(s1_cur);
  assign pprev1 = pt_pos(s1_prev);

  logic [POS_W-1:0] s2_d;
  logic [POS_W-1:0] s2_a;
  logic [POS_W-1:0] s2_b;
  colour_t          s2_cur;
  colour_t          s2_prev;
  logic             s2_direct;
  logic             s2_empty;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_d      <= (pos1 > pprev1) ? pos1 - pprev1 : '0;
      s2_a      <= s1_v - pprev1;
      s2_b      <= pos1 - s1_v;
      s2_cur    <= pt_colour(s1_cur);
      s2_prev   <= pt_colour(s1_prev);
      s2_direct <= s1_direct || (pos1 <= pprev1) || (s1_v < pprev1);
      s2_empty  <= s1_empty;
    end
  end

  wide_t            s3_pa;
  wide_t            s3_pb;
  logic [POS_W-1:0] s3_d;
  colour_t          s3_cur;
  logic             s3_direct;
  logic             s3_empty;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        s3_pa[c] <= NUM_W'(s2_cur[c]) * NUM_W'(s2_a);
        s3_pb[c] <= NUM_W'(s2_prev[c]) * NUM_W'(s2_b);
      end
      s3_d      <= s2_d;
      s3_cur    <= s2_cur;
      s3_direct <= s2_direct;
      s3_empty  <= s2_empty;
    end
  end

  // Restoring division, two quotient bits per stage; the quotient never exceeds 255.
  wide_t            dv_rem    [DIV_STAGES+1];
  colour_t          dv_q      [DIV_STAGES+1];
  logic [POS_W-1:0] dv_d      [DIV_STAGES+1];
  colour_t          dv_cur    [DIV_STAGES+1];
  logic             dv_direct [DIV_STAGES+1];
  logic             dv_empty  [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        dv_rem[0][c] <= s3_pa[c] + s3_pb[c];
      end
      dv_q[0]      <= '0;
      dv_d[0]      <= s3_d;
      dv_cur[0]    <= s3_cur;
      dv_direct[0] <= s3_direct;
      dv_empty[0]  <= s3_empty;
    end
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    wide_t   rem_next;
    colour_t q_next;

    always_comb begin
      int               j;
      logic [NUM_W-1:0] trial;
      rem_next = dv_rem[s-1];
      q_next   = dv_q[s-1];
      for (int c = 0; c < NUM_CHAN; c++) begin
        for (int t = 0; t < DIV_BITS; t++) begin
          j     = CHAN_W - 1 - (s - 1) * DIV_BITS - t;
          trial = NUM_W'(dv_d[s-1]) << j;
          if (rem_next[c] >= trial) begin
            rem_next[c]  = rem_next[c] - trial;
            q_next[c][j] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[3+s]) begin
        dv_rem[s]    <= rem_next;
        dv_q[s]      <= q_next;
        dv_d[s]      <= dv_d[s-1];
        dv_cur[s]    <= dv_cur[s-1];
        dv_direct[s] <= dv_direct[s-1];
        dv_empty[s]  <= dv_empty[s-1];
      end
    end
  end

  colour_t out_col;

  assign out_col = dv_direct[DIV_STAGES] ? dv_cur[DIV_STAGES] : dv_q[DIV_STAGES];

  assign pix_out.valid       = vld[STAGES-1];
  assign pix_out.chan_zero   = out_col[0];
  assign pix_out.chan_one    = out_col[1];
  assign pix_out.chan_two    = out_col[2];
  assign pix_out.empty_error = dv_empty[DIV_STAGES];

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gpl_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] level;
    colour_t          colour;
    logic             empty;
  } shade_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [POINT_W-1:0]   cfg_data;

  gpl_in_if  pix_in();
  gpl_out_if pix_out();

  gradient_palette_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .pix_out   (pix_out)
  );

  logic [COUNT_W-1:0] pal_count;
  logic [POINT_W-1:0] pal_point [7];

  shade_t shade_queue [$];
  int     mismatch_count  = 0;
  int     requests_sent   = 0;
  int     palettes_loaded = 0;
  int     send_idle_pct   = 0;
  int     recv_idle_pct   = 0;

  always #5 clk = ~clk;

  function automatic shade_t predict_shade(input logic [POS_W-1:0] level);
    shade_t             shade;
    logic [POINT_W-1:0] hi_pt;
    logic [POINT_W-1:0] lo_pt;
    bit                 found;
    int                 idx;
    int                 pos_hi;
    int                 pos_lo;
    int                 span;
    int                 hi_c;
    int                 lo_c;
    int                 acc;
    shade       = '0;
    shade.level = level;
    if (pal_count == 0) begin
      shade.empty = 1'b1;
      return shade;
    end
    found = 1'b0;
    idx   = 0;
    for (int k = 0; k < 7; k++) begin
      if (!found && k < int'(pal_count) && level < pal_point[k][31:24]) begin
        found = 1'b1;
        idx   = k;
      end
    end
    if (!found) begin
      hi_pt = pal_point[pal_count - 1];
      for (int c = 0; c < NUM_CHAN; c++) shade.colour[c] = hi_pt[23 - 8*c -: 8];
      return shade;
    end
    hi_pt  = pal_point[idx];
    lo_pt  = (idx == 0) ? pal_point[0] : pal_point[idx - 1];
    pos_hi = int'(hi_pt[31:24]);
    pos_lo = int'(lo_pt[31:24]);
    span   = (pos_hi > pos_lo) ? pos_hi - pos_lo : 0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      hi_c = int'(hi_pt[23 - 8*c -: 8]);
      lo_c = int'(lo_pt[23 - 8*c -: 8]);
      if (idx != 0 && span != 0 && int'(level) >= pos_lo) begin
        acc = (hi_c * (int'(level) - pos_lo) + lo_c * (pos_hi - int'(level))) / span;
        shade.colour[c] = acc[7:0];
      end else begin
        shade.colour[c] = hi_c[7:0];
      end
    end
    return shade;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && pix_in.valid && pix_in.ready) begin
      shade_queue = {shade_queue, predict_shade(pix_in.intensity)};
      requests_sent++;
    end
  end

  always @(posedge clk) begin
    shade_t want;
    string  tag;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (shade_queue.size() == 0) begin
        report_mismatch("result with no request waiting", 0, 0);
      end else begin
        want = shade_queue.pop_front();
        tag  = $sformatf("intensity %02h", want.level);
        if (pix_out.chan_zero != want.colour[0])
          report_mismatch({tag, " chan_zero"}, pix_out.chan_zero, want.colour[0]);
        if (pix_out.chan_one != want.colour[1])
          report_mismatch({tag, " chan_one"}, pix_out.chan_one, want.colour[1]);
        if (pix_out.chan_two != want.colour[2])
          report_mismatch({tag, " chan_two"}, pix_out.chan_two, want.colour[2]);
        if (pix_out.empty_error !== want.empty)
          report_mismatch({tag, " empty_error"}, pix_out.empty_error, want.empty);
      end
    end
  end

  always @(posedge clk) begin
    pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_level(input logic [POS_W-1:0] level);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid     <= 1'b1;
    pix_in.intensity <= level;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
  endtask

  task automatic settle();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (shade_queue.size() != 0) @(posedge clk);
  endtask

  task automatic load_palette(input logic [COUNT_W-1:0] count,
                              input logic [POINT_W-1:0] pts [7]);
    cfg_we    <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_data  <= POINT_W'(count);
    @(posedge clk);
    for (int k = 0; k < 7; k++) begin
      cfg_index <= CFG_IDX_W'(REG_POINT_BASE + k);
      cfg_data  <= pts[k];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    pal_count = count;
    pal_point = pts;
    palettes_loaded++;
  endtask

  task automatic test_reset_palette();
    send_level(8'h00);
    send_level(8'h80);
    send_level(8'hFE);
    send_level(8'hFF);
    settle();
  endtask

  task automatic test_empty_palette();
    load_palette(3'd0, '{32'h40FFFFFF, 32'h80123456, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    send_level(8'h00);
    send_level(8'hFF);
    settle();
  endtask

  task automatic test_extreme_points();
    load_palette(3'd7, '{32'h00000000, 32'h10FFFFFF, 32'h8000FF00, 32'hF0FF0080,
                         32'hFFFFFFFF, 32'hFF123456, 32'hFF000000});
    send_level(8'h00);
    send_level(8'h0F);
    send_level(8'h10);
    send_level(8'h7F);
    send_level(8'h80);
    send_level(8'hEF);
    send_level(8'hF0);
    send_level(8'hFE);
    send_level(8'hFF);
    settle();
  endtask

  task automatic test_single_point();
    load_palette(3'd1, '{32'h80ABCDEF, 32'hFF000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    send_level(8'h00);
    send_level(8'h7F);
    send_level(8'h80);
    settle();
  endtask

  task automatic test_unordered_points();
    load_palette(3'd4, '{32'h80FF0000, 32'h2000FF00, 32'hC00000FF, 32'h4055AA55,
                         32'hFFFFFFFF, 32'h0, 32'h0});
    send_level(8'h10);
    send_level(8'h30);
    send_level(8'h90);
    send_level(8'hD0);
    settle();
  endtask

  task automatic test_random_palettes(input int palettes, input bit hold_midway);
    logic [POINT_W-1:0] pts [7];
    logic [POS_W-1:0]   marks [$];
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   level;
    int                 burst;
    for (int p = 0; p < palettes; p++) begin
      marks.delete();
      for (int k = 0; k < 7; k++) marks = {marks, POS_W'($urandom)};
      if ($urandom_range(99) < 80) marks.sort();
      for (int k = 0; k < 7; k++) pts[k] = {marks[k], 24'($urandom)};
      if ($urandom_range(99) < 12) count = COUNT_W'($urandom_range(1));
      else count = COUNT_W'($urandom_range(7, 2));
      load_palette(count, pts);
      burst = $urandom_range(50, 30);
      for (int n = 0; n < burst; n++) begin
        if (hold_midway && n == burst / 2) settle();
        if ($urandom_range(99) < 30)
          level = marks[$urandom_range(6)] + POS_W'($urandom_range(2)) - 8'd1;
        else
          level = POS_W'($urandom);
        send_level(level);
      end
      settle();
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    pix_in.valid     <= 1'b0;
    pix_in.intensity <= '0;
    pal_count         = COUNT_RESET;
    for (int k = 0; k < 7; k++) pal_point[k] = '0;
    pal_point[1]      = POINT1_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 65;
    test_reset_palette();
    test_empty_palette();
    test_extreme_points();
    test_single_point();
    test_unordered_points();
    test_random_palettes(8, 1'b0);

    send_idle_pct = 65;
    recv_idle_pct = 7;
    test_random_palettes(8, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_palettes(8, 1'b1);

    settle();
    repeat (20) @(posedge clk);
    $display("Checked %0d requests across %0d palette settings, from an empty palette",
             requests_sent, palettes_loaded);
    $display("to seven points, ordered and unordered; %0d mismatches seen.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d results still outstanding.", shade_queue.size());
    $display("status: fail");
    $finish;
  end

endmodule
